// ===== src/lcr_pkg.sv =====
// Shared types and fixed-point constants for the lock-joint rotational rows block.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package lcr_pkg;

  // Fraction bits of the Q-format inputs and outputs.
  localparam int FRAC_BITS = 15;

  localparam int IN_W    = 16;             // quaternion part width
  localparam int OUT_W   = 16;             // result field width
  localparam int AXC_W   = 18;             // rotated-axis component width
  localparam int PROD_W  = 2 * IN_W;       // quaternion part product
  // Rotation-matrix entry before rounding: covers 1.0 and twice a sum of two products.
  localparam int ENT_W   = (2 * FRAC_BITS + 3 > PROD_W + 3) ? 2 * FRAC_BITS + 3 : PROD_W + 3;
  localparam int CPROD_W = 2 * AXC_W;      // axis component product
  localparam int CRS_W   = CPROD_W + 2;    // cross or dot sum before rounding

  localparam int AXC_MAX = 2 ** (AXC_W - 1) - 1;
  localparam int AXC_MIN = -(2 ** (AXC_W - 1));
  localparam int OUT_MAX = 2 ** (OUT_W - 1) - 1;
  localparam int OUT_MIN = -(2 ** (OUT_W - 1));

  typedef logic signed [IN_W-1:0]    qc_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [AXC_W-1:0]   axc_t;
  typedef logic signed [CPROD_W-1:0] cprod_t;
  typedef logic signed [OUT_W-1:0]   oc_t;

  typedef struct packed {
    qc_t w;
    qc_t x;
    qc_t y;
    qc_t z;
  } quat_t;

  // All pairwise products that the rotation matrix needs.
  typedef struct packed {
    prod_t xx;
    prod_t yy;
    prod_t zz;
    prod_t xy;
    prod_t wz;
    prod_t xz;
    prod_t wy;
    prod_t yz;
    prod_t wx;
  } qprod_t;

  typedef struct packed {
    axc_t x;
    axc_t y;
    axc_t z;
  } vec_t;

  // The three rotated basis axes of one body.
  typedef struct packed {
    vec_t ex;
    vec_t ey;
    vec_t ez;
  } frame_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef struct packed {
    axis_t axis;
    logic  last;
  } tag_t;

  // Products p.a * q.b of the two paired axes, named by a and b.
  typedef struct packed {
    cprod_t yz;
    cprod_t zy;
    cprod_t zx;
    cprod_t xz;
    cprod_t xy;
    cprod_t yx;
    cprod_t xx;
    cprod_t yy;
    cprod_t zz;
  } cprods_t;

  typedef struct packed {
    axis_t axis;
    oc_t   jac_a_x;
    oc_t   jac_a_y;
    oc_t   jac_a_z;
    oc_t   jac_b_x;
    oc_t   jac_b_y;
    oc_t   jac_b_z;
    oc_t   violation;
    logic  last;
  } res_t;

endpackage

`default_nettype wire

// ===== src/lcr_rotate.sv =====
// Two-stage pipeline that turns both body quaternions into their rotated basis axes.
// Depends on lcr_pkg for the quaternion, product and frame types.
`default_nettype none

module lcr_rotate (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           item_valid,
  output logic                item_ready,
  input  wire lcr_pkg::quat_t qa,
  input  wire lcr_pkg::quat_t qb,
  output logic                frm_valid,
  input  wire logic           frm_ready,
  output lcr_pkg::frame_t     fa,
  output lcr_pkg::frame_t     fb
);

  localparam logic signed [lcr_pkg::ENT_W-1:0] ENT_ONE =
    lcr_pkg::ENT_W'(1) <<< (2 * lcr_pkg::FRAC_BITS);
  localparam logic signed [lcr_pkg::ENT_W-1:0] ENT_RND =
    lcr_pkg::ENT_W'(1) <<< (lcr_pkg::FRAC_BITS - 1);

  function automatic lcr_pkg::qprod_t qmul(input lcr_pkg::quat_t q);
    lcr_pkg::qprod_t r;
    r.xx = q.x * q.x;
    r.yy = q.y * q.y;
    r.zz = q.z * q.z;
    r.xy = q.x * q.y;
    r.wz = q.w * q.z;
    r.xz = q.x * q.z;
    r.wy = q.w * q.y;
    r.yz = q.y * q.z;
    r.wx = q.w * q.x;
    return r;
  endfunction

  function automatic logic signed [lcr_pkg::ENT_W-1:0] ext(input lcr_pkg::prod_t v);
    return lcr_pkg::ENT_W'(v);
  endfunction

  // Round half up to the output fraction, then clamp to the axis component range.
  function automatic lcr_pkg::axc_t to_axis(input logic signed [lcr_pkg::ENT_W-1:0] v);
    logic signed [lcr_pkg::ENT_W-1:0] t;
    lcr_pkg::axc_t r;
    t = (v + ENT_RND) >>> lcr_pkg::FRAC_BITS;
    if (t > lcr_pkg::AXC_MAX) begin
      r = lcr_pkg::AXC_W'(lcr_pkg::AXC_MAX);
    end else if (t < lcr_pkg::AXC_MIN) begin
      r = lcr_pkg::AXC_W'(lcr_pkg::AXC_MIN);
    end else begin
      r = t[lcr_pkg::AXC_W-1:0];
    end
    return r;
  endfunction

  function automatic lcr_pkg::frame_t entries(input lcr_pkg::qprod_t p);
    lcr_pkg::frame_t f;
    f.ex.x = to_axis(ENT_ONE - ((ext(p.yy) + ext(p.zz)) <<< 1));
    f.ex.y = to_axis((ext(p.xy) + ext(p.wz)) <<< 1);
    f.ex.z = to_axis((ext(p.xz) - ext(p.wy)) <<< 1);
    f.ey.x = to_axis((ext(p.xy) - ext(p.wz)) <<< 1);
    f.ey.y = to_axis(ENT_ONE - ((ext(p.xx) + ext(p.zz)) <<< 1));
    f.ey.z = to_axis((ext(p.yz) + ext(p.wx)) <<< 1);
    f.ez.x = to_axis((ext(p.xz) + ext(p.wy)) <<< 1);
    f.ez.y = to_axis((ext(p.yz) - ext(p.wx)) <<< 1);
    f.ez.z = to_axis(ENT_ONE - ((ext(p.xx) + ext(p.yy)) <<< 1));
    return f;
  endfunction

  logic            prod_valid;
  logic            prod_ready;
  logic            out_ready;
  lcr_pkg::qprod_t pa;
  lcr_pkg::qprod_t pb;

  assign out_ready  = !frm_valid || frm_ready;
  assign prod_ready = !prod_valid || out_ready;
  assign item_ready = prod_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (prod_ready) begin
      prod_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && prod_ready) begin
      pa <= qmul(qa);
      pb <= qmul(qb);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frm_valid <= 1'b0;
    end else if (out_ready) begin
      frm_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_valid && out_ready) begin
      fa <= entries(pa);
      fb <= entries(pb);
    end
  end

endmodule

`default_nettype wire

// ===== src/lcr_serial.sv =====
// Holds the two rotated frames of one item and hands out the three axis pairs in turn.
// Depends on lcr_pkg for the frame, vector and tag types.
`default_nettype none

module lcr_serial (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            frm_valid,
  output logic                 frm_ready,
  input  wire lcr_pkg::frame_t fa,
  input  wire lcr_pkg::frame_t fb,
  output logic                 pair_valid,
  input  wire logic            pair_ready,
  output lcr_pkg::vec_t        p,
  output lcr_pkg::vec_t        q,
  output lcr_pkg::tag_t        tag
);

  logic            valid;
  lcr_pkg::axis_t  cnt;
  lcr_pkg::axis_t  cnt_next;
  lcr_pkg::frame_t fa_r;
  lcr_pkg::frame_t fb_r;
  logic            fire;
  logic            last_w;

  assign last_w     = (cnt == lcr_pkg::AXIS_Z);
  assign fire       = valid && pair_ready;
  assign frm_ready  = !valid || (fire && last_w);
  assign pair_valid = valid;
  assign tag.axis   = cnt;
  assign tag.last   = last_w;

  always_comb begin
    unique case (cnt)
      lcr_pkg::AXIS_X: cnt_next = lcr_pkg::AXIS_Y;
      lcr_pkg::AXIS_Y: cnt_next = lcr_pkg::AXIS_Z;
      default:         cnt_next = lcr_pkg::AXIS_X;
    endcase
  end

  // Pairing of body B axis with body A axis for each equation.
  always_comb begin
    unique case (cnt)
      lcr_pkg::AXIS_X: begin
        p = fb_r.ez;
        q = fa_r.ey;
      end
      lcr_pkg::AXIS_Y: begin
        p = fb_r.ex;
        q = fa_r.ez;
      end
      lcr_pkg::AXIS_Z: begin
        p = fb_r.ey;
        q = fa_r.ex;
      end
      default: begin
        p = fb_r.ez;
        q = fa_r.ey;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      cnt   <= lcr_pkg::AXIS_X;
    end else if (frm_valid && frm_ready) begin
      valid <= 1'b1;
      cnt   <= lcr_pkg::AXIS_X;
    end else if (fire) begin
      if (last_w) begin
        valid <= 1'b0;
      end
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (frm_valid && frm_ready) begin
      fa_r <= fa;
      fb_r <= fb;
    end
  end

`ifndef ASSERT_OFF
  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    valid && (cnt != lcr_pkg::AXIS_Z) |-> !frm_ready)
    else $error("new frame accepted before the held item is finished");

  a_stall_keeps: assert property (@(posedge clk) disable iff (rst)
    valid && !pair_ready |=> valid && $stable(cnt))
    else $error("held pair lost or advanced during a stall");

  a_x_then_y: assert property (@(posedge clk) disable iff (rst)
    valid && pair_ready && (cnt == lcr_pkg::AXIS_X) |=> valid && (cnt == lcr_pkg::AXIS_Y))
    else $error("y equation did not follow the x equation");
`endif

endmodule

`default_nettype wire

// ===== src/lcr_cross.sv =====
// Two-stage pipeline forming the cross and dot products of one axis pair, rounded and saturated.
// Depends on lcr_pkg for the vector, product, tag and result types.
`default_nettype none

module lcr_cross (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          pair_valid,
  output logic               pair_ready,
  input  wire lcr_pkg::vec_t p,
  input  wire lcr_pkg::vec_t q,
  input  wire lcr_pkg::tag_t tag,
  output logic               res_valid,
  input  wire logic          res_ready,
  output lcr_pkg::res_t      res
);

  localparam logic signed [lcr_pkg::CRS_W-1:0] CRS_RND =
    lcr_pkg::CRS_W'(1) <<< (lcr_pkg::FRAC_BITS - 1);

  function automatic logic signed [lcr_pkg::CRS_W-1:0] cext(input lcr_pkg::cprod_t v);
    return lcr_pkg::CRS_W'(v);
  endfunction

  // Round half up to the output fraction, then clamp to the 16-bit range.
  function automatic lcr_pkg::oc_t to_out(input logic signed [lcr_pkg::CRS_W-1:0] v);
    logic signed [lcr_pkg::CRS_W-1:0] t;
    lcr_pkg::oc_t r;
    t = (v + CRS_RND) >>> lcr_pkg::FRAC_BITS;
    if (t > lcr_pkg::OUT_MAX) begin
      r = lcr_pkg::OUT_W'(lcr_pkg::OUT_MAX);
    end else if (t < lcr_pkg::OUT_MIN) begin
      r = lcr_pkg::OUT_W'(lcr_pkg::OUT_MIN);
    end else begin
      r = t[lcr_pkg::OUT_W-1:0];
    end
    return r;
  endfunction

  logic             prod_valid;
  logic             prod_ready;
  logic             out_ready;
  lcr_pkg::cprods_t pr;
  lcr_pkg::tag_t    tag_r;

  logic signed [lcr_pkg::CRS_W-1:0] cx;
  logic signed [lcr_pkg::CRS_W-1:0] cy;
  logic signed [lcr_pkg::CRS_W-1:0] cz;
  logic signed [lcr_pkg::CRS_W-1:0] dt;

  assign out_ready  = !res_valid || res_ready;
  assign prod_ready = !prod_valid || out_ready;
  assign pair_ready = prod_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (prod_ready) begin
      prod_valid <= pair_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pair_valid && prod_ready) begin
      pr.yz <= p.y * q.z;
      pr.zy <= p.z * q.y;
      pr.zx <= p.z * q.x;
      pr.xz <= p.x * q.z;
      pr.xy <= p.x * q.y;
      pr.yx <= p.y * q.x;
      pr.xx <= p.x * q.x;
      pr.yy <= p.y * q.y;
      pr.zz <= p.z * q.z;
      tag_r <= tag;
    end
  end

  assign cx = cext(pr.yz) - cext(pr.zy);
  assign cy = cext(pr.zx) - cext(pr.xz);
  assign cz = cext(pr.xy) - cext(pr.yx);
  assign dt = cext(pr.xx) + cext(pr.yy) + cext(pr.zz);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_ready) begin
      res_valid <= prod_valid;
    end
  end

  // The body B row is the negated exact value, rounded on its own.
  always_ff @(posedge clk) begin
    if (prod_valid && out_ready) begin
      res.axis      <= tag_r.axis;
      res.last      <= tag_r.last;
      res.jac_a_x   <= to_out(cx);
      res.jac_a_y   <= to_out(cy);
      res.jac_a_z   <= to_out(cz);
      res.jac_b_x   <= to_out(-cx);
      res.jac_b_y   <= to_out(-cy);
      res.jac_b_z   <= to_out(-cz);
      res.violation <= to_out(dt);
    end
  end

endmodule

`default_nettype wire

// ===== src/lock_constraint_rotation_rows.sv =====
// Each result word passes rotate stages 1 and 2, the serializer and cross stages 1 and 2 in that order.
// The single output channel gives one word a cycle while not stalled, and each item yields three words.
// The x, y and z words of an item follow one another in that order when the output is never stalled.
// Reset (rst, synchronous, active high) clears every valid bit; no data register is reset.
// Top level of the lock-joint rotational rows block; instantiates lcr_rotate, lcr_serial
// and lcr_cross, and uses lcr_pkg for all shared types.
`default_nettype none

module lock_constraint_rotation_rows (
  input  wire logic                      clk,
  input  wire logic                      rst,

  input  wire logic                      item_valid,
  output logic                           item_ready,
  input  wire logic signed [lcr_pkg::IN_W-1:0] a_w,
  input  wire logic signed [lcr_pkg::IN_W-1:0] a_x,
  input  wire logic signed [lcr_pkg::IN_W-1:0] a_y,
  input  wire logic signed [lcr_pkg::IN_W-1:0] a_z,
  input  wire logic signed [lcr_pkg::IN_W-1:0] b_w,
  input  wire logic signed [lcr_pkg::IN_W-1:0] b_x,
  input  wire logic signed [lcr_pkg::IN_W-1:0] b_y,
  input  wire logic signed [lcr_pkg::IN_W-1:0] b_z,

  output logic                           res_valid,
  input  wire logic                      res_ready,
  output logic [1:0]                     axis,
  output logic signed [lcr_pkg::OUT_W-1:0] jac_a_x,
  output logic signed [lcr_pkg::OUT_W-1:0] jac_a_y,
  output logic signed [lcr_pkg::OUT_W-1:0] jac_a_z,
  output logic signed [lcr_pkg::OUT_W-1:0] jac_b_x,
  output logic signed [lcr_pkg::OUT_W-1:0] jac_b_y,
  output logic signed [lcr_pkg::OUT_W-1:0] jac_b_z,
  output logic signed [lcr_pkg::OUT_W-1:0] violation,
  output logic                           last
);

  // The datapath is a chain of elastic stages, each with its own valid bit and a ready
  // that passes back combinationally through every stage ahead, so a stall anywhere holds every word in place:
  //   rotate stage 1  - eighteen 16x16 products of the quaternion parts
  //   rotate stage 2  - rotation-matrix entries, rounded half up, clamped to 18 bits
  //   serializer      - holds both frames and steps through the x, y and z equations
  //   cross stage 1   - nine 18x18 products of the selected axis pair
  //   cross stage 2   - cross and dot sums, rounded, saturated; this is the output register
  // The serializer takes a new item in the same cycle its last word moves on, so items
  // stream without a bubble as long as the output keeps taking words.

  lcr_pkg::quat_t  qa;
  lcr_pkg::quat_t  qb;
  lcr_pkg::frame_t fa;
  lcr_pkg::frame_t fb;
  logic            frm_valid;
  logic            frm_ready;
  logic            pair_valid;
  logic            pair_ready;
  lcr_pkg::vec_t   p;
  lcr_pkg::vec_t   q;
  lcr_pkg::tag_t   tag;
  lcr_pkg::res_t   res;

  assign qa = '{w: a_w, x: a_x, y: a_y, z: a_z};
  assign qb = '{w: b_w, x: b_x, y: b_y, z: b_z};

  lcr_rotate u_rotate (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .qa         (qa),
    .qb         (qb),
    .frm_valid  (frm_valid),
    .frm_ready  (frm_ready),
    .fa         (fa),
    .fb         (fb)
  );

  lcr_serial u_serial (
    .clk        (clk),
    .rst        (rst),
    .frm_valid  (frm_valid),
    .frm_ready  (frm_ready),
    .fa         (fa),
    .fb         (fb),
    .pair_valid (pair_valid),
    .pair_ready (pair_ready),
    .p          (p),
    .q          (q),
    .tag        (tag)
  );

  lcr_cross u_cross (
    .clk        (clk),
    .rst        (rst),
    .pair_valid (pair_valid),
    .pair_ready (pair_ready),
    .p          (p),
    .q          (q),
    .tag        (tag),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // Result word fields come straight from the output register of the cross stage.
  assign axis      = res.axis;
  assign jac_a_x   = res.jac_a_x;
  assign jac_a_y   = res.jac_a_y;
  assign jac_a_z   = res.jac_a_z;
  assign jac_b_x   = res.jac_b_x;
  assign jac_b_y   = res.jac_b_y;
  assign jac_b_z   = res.jac_b_z;
  assign violation = res.violation;
  assign last      = res.last;

endmodule

`default_nettype wire
